>>> hdl/sfrm_pkg.sv
// Shared constants and controller/datapath interface types for the sensor frame receiver.
package sfrm_pkg;

  // Item kinds carried in the input tuser field
  localparam logic [1:0] MODE_RX      = 2'd0;
  localparam logic [1:0] MODE_CLR_EXT = 2'd1;
  localparam logic [1:0] MODE_CLR_DEV = 2'd2;

  // Frame marker bytes
  localparam logic [7:0] HEAD_BYTE = 8'hFF;
  localparam logic [7:0] DEV_BYTE  = 8'hC6;

  // Frame commands
  localparam logic [7:0] CMD_SAMPLES = 8'hA0;
  localparam logic [7:0] CMD_STOP    = 8'hA1;
  localparam logic [7:0] CMD_ID      = 8'hA2;
  localparam logic [7:0] CMD_DATE    = 8'hA3;
  localparam logic [7:0] CMD_CFG     = 8'hA9;

  // Fixed byte positions in the frame
  localparam int POS_DEV  = 1;
  localparam int POS_LEN  = 2;
  localparam int POS_CHK  = 3;
  localparam int POS_CMD  = 4;
  localparam int POS_SMP  = 5;

  // Extreme reset values
  localparam logic [15:0] MAX_INIT = 16'h0000;
  localparam logic [15:0] MIN_INIT = 16'hFFFF;

  // Packed result width (44 bits of fields padded to whole bytes)
  localparam int OUT_W = 48;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;       // act on the accepted input transaction
    logic fold_rd;    // read one stored sample pair
    logic set_ready;  // sample sweep finished
    logic load_out;   // capture the result into the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fold_req;   // last byte closed a valid sample frame
    logic out_busy;   // output register holds a result not yet taken
  } ctl_sts_t;

endpackage

>>> hdl/sensor_frame_receiver_minmax.sv
// Top level of the sensor frame receiver with running sample extremes.
//
// Each input transaction carries one UART byte (mode 0) or a clear event (mode 1 clears
// the extremes and the ready flag, mode 2 clears the device flag) and yields exactly one
// result transaction. After a plain byte or event is accepted, the controller passes through
// its check and output states before the next byte can be accepted. A byte that closes
// a valid sample frame (command 0xA0) also runs a sweep over the frame store between
// those states that reads one 16-bit sample per cycle through the store's two read ports.
// A result waiting in the output register does not hold off the next byte; only loading
// a new result waits for the old one to be taken. The frame store has per-entry valid bits
// cleared by reset, so the block is ready straight out of reset with no clearing pass.
module sensor_frame_receiver_minmax #(
  parameter int FRAME_BYTES  = 55,
  parameter int SAMPLE_COUNT = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] frame_accepted, [1] checksum_error, [9:2] frame_command, [25:10] sample_max,
  // [41:26] sample_min, [42] samples_ready, [43] device_flag, [47:44] zero
  output logic [47:0] out_tdata
);
  import sfrm_pkg::*;

  localparam int KW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

  ctl_cmd_t      cmd;
  ctl_sts_t      sts;
  logic [KW-1:0] fold_idx;

  sfrm_ctrl #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .KW           (KW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .fold_idx  (fold_idx)
  );

  sfrm_datapath #(
    .FRAME_BYTES  (FRAME_BYTES),
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .KW           (KW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .fold_idx   (fold_idx),
    .in_mode    (in_tuser),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/sfrm_datapath.sv
// Datapath: frame store, frame checks, checksum, sample extremes and output register.
module sfrm_datapath #(
  parameter int FRAME_BYTES  = 55,
  parameter int SAMPLE_COUNT = 25,
  parameter int KW           = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfrm_pkg::ctl_cmd_t        cmd,
  output sfrm_pkg::ctl_sts_t        sts,
  input  logic [KW-1:0]             fold_idx,
  input  logic [1:0]                in_mode,
  input  logic [7:0]                in_byte,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sfrm_pkg::OUT_W-1:0] out_tdata
);
  import sfrm_pkg::*;

  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int RAW = $clog2(2 * SAMPLE_COUNT + POS_SMP + 1);

  // Frame store and per-entry valid bits (an unwritten entry reads as zero)
  logic [7:0] store_mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] vld_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [15:0]   max_r, max_nxt;
  logic [15:0]   min_r, min_nxt;
  logic          rdy_r, rdy_nxt;
  logic          dev_r, dev_nxt;
  logic          acc_r, acc_nxt;
  logic          bad_r, bad_nxt;
  logic          fold_req_r, fold_req_nxt;

  // Sample read pipeline
  logic [7:0] hi_r, lo_r;
  logic       hi_ok_r, lo_ok_r, rd_pend_r;

  // Output register
  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;

  // Byte handling terms
  logic [CW-1:0] pos, cnt1;
  logic [7:0]    sum_inc, chk_eff, cmd_eff, csum;
  logic [8:0]    len_p2;
  logic          at_end, csum_ok;

  // Sample read addresses
  logic [RAW-1:0] hi_addr, lo_addr;
  logic           hi_in, lo_in;
  logic [15:0]    smp;

  // Wrap the write position after a full store
  assign pos     = (cnt_r == CW'(FRAME_BYTES)) ? '0 : cnt_r;
  assign cnt1    = pos + CW'(1);
  assign sum_inc = (pos >= CW'(POS_CMD)) ? sum_r + in_byte : 8'd0;
  assign chk_eff = (pos == CW'(POS_CHK)) ? in_byte : chk_r;
  assign cmd_eff = (pos == CW'(POS_CMD)) ? in_byte : cmd_r;
  assign len_p2  = {1'b0, len_r} + 9'd2;
  assign at_end  = (cnt1 >= CW'(POS_CMD)) && (9'(cnt1) == len_p2);
  assign csum    = len_r + sum_inc;
  assign csum_ok = (csum == chk_eff);

  assign hi_addr = RAW'(2 * 32'(fold_idx) + POS_SMP);
  assign lo_addr = RAW'(2 * 32'(fold_idx) + POS_SMP + 1);
  assign hi_in   = 32'(hi_addr) < FRAME_BYTES;
  assign lo_in   = 32'(lo_addr) < FRAME_BYTES;
  assign smp     = {(hi_ok_r ? hi_r : 8'd0), (lo_ok_r ? lo_r : 8'd0)};

  // Next-state logic for frame tracking and extremes
  always_comb begin
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    chk_nxt      = chk_r;
    cmd_nxt      = cmd_r;
    sum_nxt      = sum_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    rdy_nxt      = rdy_r;
    dev_nxt      = dev_r;
    acc_nxt      = acc_r;
    bad_nxt      = bad_r;
    fold_req_nxt = fold_req_r;

    if (cmd.take) begin
      acc_nxt      = 1'b0;
      bad_nxt      = 1'b0;
      fold_req_nxt = 1'b0;
      unique case (in_mode)
        MODE_RX: begin
          // Shadow the fixed header fields as they are stored
          if (pos == CW'(POS_LEN)) len_nxt = in_byte;
          if (pos == CW'(POS_CHK)) chk_nxt = in_byte;
          if (pos == CW'(POS_CMD)) cmd_nxt = in_byte;
          sum_nxt = sum_inc;
          cnt_nxt = cnt1;
          if (pos == '0) begin
            if (in_byte != HEAD_BYTE) cnt_nxt = '0;
          end else if (pos == CW'(POS_DEV)) begin
            if (in_byte != DEV_BYTE) cnt_nxt = '0;
          end else if (at_end) begin
            cnt_nxt = '0;
            if (csum_ok) begin
              acc_nxt = 1'b1;
              if (cmd_eff == CMD_SAMPLES) fold_req_nxt = 1'b1;
              case (cmd_eff) inside
                CMD_STOP, CMD_ID, CMD_DATE, CMD_CFG: dev_nxt = 1'b1;
                default: ;
              endcase
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end
        MODE_CLR_EXT: begin
          max_nxt = MAX_INIT;
          min_nxt = MIN_INIT;
          rdy_nxt = 1'b0;
        end
        MODE_CLR_DEV: begin
          dev_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // Fold one sample per cycle into the extremes
    if (rd_pend_r) begin
      if (smp > max_r) max_nxt = smp;
      if (smp < min_r) min_nxt = smp;
    end
    if (cmd.set_ready) rdy_nxt = 1'b1;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      cnt_r      <= '0;
      len_r      <= '0;
      chk_r      <= '0;
      cmd_r      <= '0;
      sum_r      <= '0;
      max_r      <= MAX_INIT;
      min_r      <= MIN_INIT;
      rdy_r      <= 1'b0;
      dev_r      <= 1'b0;
      acc_r      <= 1'b0;
      bad_r      <= 1'b0;
      fold_req_r <= 1'b0;
      rd_pend_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.take && in_mode == MODE_RX) vld_r[AW'(pos)] <= 1'b1;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      chk_r      <= chk_nxt;
      cmd_r      <= cmd_nxt;
      sum_r      <= sum_nxt;
      max_r      <= max_nxt;
      min_r      <= min_nxt;
      rdy_r      <= rdy_nxt;
      dev_r      <= dev_nxt;
      acc_r      <= acc_nxt;
      bad_r      <= bad_nxt;
      fold_req_r <= fold_req_nxt;
      rd_pend_r  <= cmd.fold_rd;
      if (cmd.load_out) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // Store write port and dual registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && in_mode == MODE_RX) store_mem[AW'(pos)] <= in_byte;
    if (cmd.fold_rd) begin
      hi_r    <= store_mem[AW'(hi_addr)];
      lo_r    <= store_mem[AW'(lo_addr)];
      hi_ok_r <= hi_in && vld_r[AW'(hi_addr)];
      lo_ok_r <= lo_in && vld_r[AW'(lo_addr)];
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {4'd0, dev_r, rdy_r, min_r, max_r, cmd_r, bad_r, acc_r};
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign sts.fold_req = fold_req_r;
  assign sts.out_busy = out_vld_r && !out_tready;

endmodule

>>> hdl/sfrm_ctrl.sv
// Controller: sequences byte handling, the sample sweep and result hand-off.
module sfrm_ctrl #(
  parameter int SAMPLE_COUNT = 25,
  parameter int KW           = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sfrm_pkg::ctl_sts_t sts,
  output sfrm_pkg::ctl_cmd_t cmd,
  output logic [KW-1:0]      fold_idx
);
  import sfrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FOLD,
    S_LAST,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic          tready_r, tready_nxt;
  logic [KW-1:0] k_r, k_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    tready_nxt    = tready_r;
    k_nxt         = k_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && tready_r) begin
          cmd.take   = 1'b1;
          tready_nxt = 1'b0;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        k_nxt     = '0;
        state_nxt = sts.fold_req ? S_FOLD : S_OUT;
      end
      S_FOLD: begin
        cmd.fold_rd = 1'b1;
        if (k_r == KW'(SAMPLE_COUNT - 1)) state_nxt = S_LAST;
        else k_nxt = k_r + KW'(1);
      end
      S_LAST: begin
        cmd.set_ready = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          tready_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tready_r <= 1'b1;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      tready_r <= tready_nxt;
      k_r      <= k_nxt;
    end
  end

  assign in_tready = tready_r;
  assign fold_idx  = k_r;

endmodule
